// ===== rtl/spsm_pkg.sv =====
// Shared widths, types and register codes for the pair-sum matcher.
// No dependencies; imported by the top level and the checker.

package spsm_pkg;

    localparam int VALUE_W    = 32;
    localparam int IDX_W      = 8;
    localparam int OUT_DATA_W = 2 * IDX_W;
    localparam int OUT_USER_W = 2;
    localparam int APB_DW     = 32;
    localparam int APB_AW     = 3;

    // register index, taken from paddr[2]
    localparam logic REG_TARGET_SUM = 1'b0;

    // tuser bit positions on the result side
    localparam int USER_FOUND    = 0;
    localparam int USER_OVERFLOW = 1;

    typedef logic [VALUE_W-1:0] t_value;
    typedef logic [IDX_W-1:0]   t_index;

endpackage

// ===== rtl/spsm_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.

module spsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/streaming_pair_sum_matcher.sv =====
// Streaming pair-sum matcher: finds an earlier element that completes the target sum.
// Depends on spsm_pkg and spsm_ram (value/position table).
//
//  channel    dir  handshake                  contents
//  s_axis     in   tvalid / tready            tdata = value, tlast = last of array
//  m_axis     out  tvalid / tready            tdata = newer, older; tuser = found, overflow
//  apb        in   psel, penable, pwrite      target_sum at byte address 0
//
// An item holds the input until its result word can load into the output register: the
// table memory is scanned one entry a cycle through its single read port, over the
// entries held for the current array (at most MAX_ITEMS), before the result is formed.
// Overflowed items and the first item of an array skip the scan.
// Synchronous active-low reset empties the table; no clearing pass is needed.
// A finished word sits in the output register while the next word is accepted.

module streaming_pair_sum_matcher #(
    parameter int MAX_ITEMS = 256
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // configuration
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [spsm_pkg::APB_AW-1:0]         paddr,
    input  logic [spsm_pkg::APB_DW-1:0]         pwdata,
    output logic [spsm_pkg::APB_DW-1:0]         prdata,
    output logic                                pready,
    // input words
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [spsm_pkg::VALUE_W-1:0]        s_axis_tdata,  // [31:0] value
    input  logic                                s_axis_tlast,
    // result words
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [spsm_pkg::OUT_DATA_W-1:0]     m_axis_tdata,  // [7:0] newer_index, [15:8] older_index
    output logic [spsm_pkg::OUT_USER_W-1:0]     m_axis_tuser   // [0] found, [1] overflow
);

    import spsm_pkg::*;

    localparam int AW = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
    localparam int CW = $clog2(MAX_ITEMS + 1);
    localparam int XW = (AW > IDX_W) ? AW : IDX_W;
    localparam int DW = VALUE_W + AW;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]         r_state, n_state;
    t_value             r_target;
    t_value             r_value;
    logic               r_last;
    t_value             r_rem;
    logic               r_rem_ok;
    logic               r_ovf;
    logic [CW-1:0]      r_idx;
    logic               r_pend;
    logic [AW-1:0]      r_pend_idx;
    logic               r_found;
    logic [AW-1:0]      r_older;
    logic               r_vhit;
    logic [AW-1:0]      r_vslot;
    logic [CW-1:0]      r_used;
    logic [CW-1:0]      r_pos;
    logic               r_out_vld;
    logic               r_out_found;
    logic               r_out_ovf;
    t_index             r_out_newer;
    t_index             r_out_older;

    logic               cfg_we;
    logic               s_acc;
    logic [VALUE_W:0]   rem_wide;
    logic               rd_en;
    logic               out_load;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    logic [DW-1:0]      rd_data;
    t_value             rd_value;
    logic [AW-1:0]      rd_pos;
    logic [XW-1:0]      pos_ext;
    logic [XW-1:0]      older_ext;

    // APB
    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite & pready & (paddr[2] == REG_TARGET_SUM);
    assign prdata = (paddr[2] == REG_TARGET_SUM) ? r_target : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_target <= '0;
        end else if (cfg_we) begin
            r_target <= pwdata;
        end
    end

    // datapath
    assign s_axis_tready = (r_state == ST_IDLE);
    assign s_acc         = s_axis_tvalid & s_axis_tready;
    assign rem_wide      = {r_target[VALUE_W-1], r_target}
                         - {s_axis_tdata[VALUE_W-1], s_axis_tdata};
    assign rd_en         = (r_state == ST_SCAN) && (r_idx < r_used);
    assign out_load      = (r_state == ST_DONE) && (!r_out_vld || m_axis_tready);
    assign wr_en         = out_load && !r_ovf;
    assign wr_addr       = r_vhit ? r_vslot : r_used[AW-1:0];
    assign rd_value      = rd_data[VALUE_W-1:0];
    assign rd_pos        = rd_data[DW-1:VALUE_W];
    assign pos_ext       = XW'(r_pos[AW-1:0]);
    assign older_ext     = XW'(r_older);

    spsm_ram #(
        .WIDTH (DW),
        .DEPTH (MAX_ITEMS)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (wr_en),
        .i_waddr (wr_addr),
        .i_wdata ({r_pos[AW-1:0], r_value}),
        .i_raddr (r_idx[AW-1:0]),
        .o_rdata (rd_data)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    if (r_pos == CW'(MAX_ITEMS) || r_used == '0) begin
                        n_state = ST_DONE;
                    end else begin
                        n_state = ST_SCAN;
                    end
                end
            end
            ST_SCAN: begin
                if (!rd_en && !r_pend) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_load) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_used    <= '0;
            r_pos     <= '0;
            r_pend    <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= rd_en;
            if (out_load) begin
                r_out_vld <= 1'b1;
                if (r_last) begin
                    r_used <= '0;
                    r_pos  <= '0;
                end else if (!r_ovf) begin
                    r_pos <= r_pos + 1'b1;
                    if (!r_vhit) begin
                        r_used <= r_used + 1'b1;
                    end
                end
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    // scan and result payload
    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_value  <= s_axis_tdata;
            r_last   <= s_axis_tlast;
            r_rem    <= rem_wide[VALUE_W-1:0];
            r_rem_ok <= (rem_wide[VALUE_W] == rem_wide[VALUE_W-1]);
            r_ovf    <= (r_pos == CW'(MAX_ITEMS));
            r_idx    <= '0;
            r_found  <= 1'b0;
            r_older  <= '0;
            r_vhit   <= 1'b0;
            r_vslot  <= '0;
        end
        if (rd_en) begin
            r_idx      <= r_idx + 1'b1;
            r_pend_idx <= r_idx[AW-1:0];
        end
        if (r_pend) begin
            if (r_rem_ok && rd_value == r_rem) begin
                r_found <= 1'b1;
                r_older <= rd_pos;
            end
            if (rd_value == r_value) begin
                r_vhit  <= 1'b1;
                r_vslot <= r_pend_idx;
            end
        end
        if (out_load) begin
            r_out_found <= r_found;
            r_out_ovf   <= r_ovf;
            r_out_newer <= r_ovf ? '0 : pos_ext[IDX_W-1:0];
            r_out_older <= older_ext[IDX_W-1:0];
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {r_out_older, r_out_newer};
    always_comb begin
        m_axis_tuser                = '0;
        m_axis_tuser[USER_FOUND]    = r_out_found;
        m_axis_tuser[USER_OVERFLOW] = r_out_ovf;
    end

endmodule

// ===== rtl/spsm_checker.sv =====
// Port-level checks for the pair-sum matcher, bound to the top level.
// Depends on spsm_pkg and streaming_pair_sum_matcher.

module spsm_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_s_tvalid,
    input logic                                i_s_tready,
    input logic                                i_m_tvalid,
    input logic                                i_m_tready,
    input logic [spsm_pkg::OUT_DATA_W-1:0]     i_m_tdata,
    input logic [spsm_pkg::OUT_USER_W-1:0]     i_m_tuser
);

    import spsm_pkg::*;

    // one word in flight on the input side
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && i_s_tready) |=> !i_s_tready)
        else $error("input accepted on consecutive cycles");

    a_ovf_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && i_m_tuser[USER_OVERFLOW])
            |-> (!i_m_tuser[USER_FOUND] && i_m_tdata == '0))
        else $error("overflow word carries a match or index");

    a_miss_older_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tuser[USER_FOUND]) |-> (i_m_tdata[OUT_DATA_W-1:IDX_W] == '0))
        else $error("older index set without a match");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("result valid after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready)
            |=> (i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser)))
        else $error("stalled result word changed");

endmodule

bind streaming_pair_sum_matcher spsm_checker u_spsm_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);
